// File: hw/rtl/ftr_pkg.sv
// Shared types, constants and the 5x7 glyph table for the text renderer.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ftr_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 32;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COUNT = 95;
  localparam int DRAW_STEPS = 2 * GLYPH_ROWS;

  localparam logic [7:0] CODE_NUL    = 8'h00;
  localparam logic [7:0] CODE_CR     = 8'h0D;
  localparam logic [7:0] CODE_LF     = 8'h0A;
  localparam logic [7:0] GLYPH_FIRST = 8'h20;
  localparam logic [7:0] GLYPH_LAST  = 8'h7E;
  localparam logic [8:0] COL_SPAN    = 9'd5;
  localparam logic [8:0] ADVANCE     = 9'd6;
  localparam logic [8:0] ROW_SPAN    = 9'd7;
  localparam logic [8:0] LINE_STEP   = 9'd8;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_DRAW  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_RIGHT  = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } reg_index_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       exec;
    logic       sweep;
    logic       draw;
    logic [3:0] step;
    logic       out_load;
  } ftr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t act;
    logic    start_draw;
    logic    sweep_last;
    logic    out_free;
  } ftr_status_t;

  // Each entry lists columns 0..4 from the high byte down; bit 0 of a column is its top pixel.
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h2424242424,
    40'h0041221408, 40'h0201510906, 40'h324979413E,
    40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000,
    40'h0041360800, 40'h0804081008
  };

  // Pixels of one glyph row, bit c for column c
  function automatic logic [GLYPH_COLS-1:0] glyph_row(input logic [6:0] idx,
                                                      input logic [2:0] r);
    logic [39:0]            g;
    logic [GLYPH_COLS-1:0]  bits;
    int                     c;
    g = (idx < 7'(GLYPH_COUNT)) ? GLYPH_ROM[idx] : '0;
    for (c = 0; c < GLYPH_COLS; c++) begin
      bits[c] = g[32 - 8 * c + int'(r)];
    end
    return bits;
  endfunction

endpackage

// File: hw/rtl/ftr_ctrl.sv
// Sequencer for the text renderer: input handshake, clearing sweep, glyph steps.
// Depends on ftr_pkg; drives the datapath through ftr_cmd_t.
`timescale 1ns / 1ps

module ftr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output ftr_pkg::ftr_cmd_t    cmd,
  input  ftr_pkg::ftr_status_t status
);
  import ftr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_SWEEP = 6'b000100,
    ST_DRAW  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  localparam logic [3:0] LAST_STEP = 4'(DRAW_STEPS - 1);

  state_t     state, state_next;
  logic [3:0] step, step_next;
  logic       item_sweep, item_sweep_next;

  always_comb begin
    state_next      = state;
    step_next       = step;
    item_sweep_next = item_sweep;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.step        = step;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.act == ACT_CLEAR) begin
          item_sweep_next = 1'b1;
          state_next      = ST_SWEEP;
        end else if (status.start_draw) begin
          step_next  = '0;
          state_next = ST_DRAW;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          item_sweep_next = 1'b0;
          state_next      = item_sweep ? ST_DONE : ST_IDLE;
        end
      end
      ST_DRAW: begin
        cmd.draw  = 1'b1;
        step_next = step + 4'd1;
        if (step == LAST_STEP) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read-modify-write lands this cycle
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      step       <= '0;
      item_sweep <= 1'b0;
    end else begin
      state      <= state_next;
      step       <= step_next;
      item_sweep <= item_sweep_next;
    end
  end

endmodule

// File: hw/rtl/ftr_datapath.sv
// Datapath of the text renderer: cursor logic, glyph rasterizer, framebuffer, result register.
// Depends on ftr_pkg (glyph table, command and status types).
`timescale 1ns / 1ps

module ftr_datapath #(
  parameter int SCREEN_WIDTH  = ftr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ftr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ftr_pkg::ftr_cmd_t    cmd,
  output ftr_pkg::ftr_status_t status,
  input  logic [1:0]           action,
  input  logic [6:0]           start_x,
  input  logic [4:0]           start_y,
  input  logic [7:0]           character_code,
  input  logic [8:0]           read_address,
  input  logic [6:0]           clip_left,
  input  logic [4:0]           clip_top,
  input  logic [6:0]           clip_right,
  input  logic [4:0]           clip_bottom,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           read_data,
  output logic [7:0]           cursor_x,
  output logic [7:0]           cursor_y,
  output logic                 halted
);
  import ftr_pkg::*;

  localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int RB_W        = $clog2(ROW_BYTES + 1);
  localparam int LIN_W       = 10 + RB_W;
  localparam int RA_W        = (ADDR_W > 9) ? ADDR_W : 9;
  localparam logic [9:0] SW10 = 10'(SCREEN_WIDTH);
  localparam logic [9:0] SH10 = 10'(SCREEN_HEIGHT);

  // latched transaction
  action_t    act_q;
  logic [6:0] sx_q;
  logic [4:0] sy_q;
  logic [7:0] code_q;
  logic [8:0] raddr_q;

  // cursor state
  logic [7:0] cursor_col, cursor_row;
  logic       stopped;

  // glyph origin after wrap
  logic [7:0] gx, gy;
  logic       rd_ok;

  // framebuffer
  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        mem_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] sweep_cnt;
  logic              sweep_last;
  logic              wr_en_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [7:0]        wr_mask_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q   <= action_t'(action);
      sx_q    <= start_x;
      sy_q    <= start_y;
      code_q  <= character_code;
      raddr_q <= read_address;
    end
  end

  // cursor decision for a character
  logic [8:0] col_p5, row_p8, row_w_p7, col_adv;
  logic [7:0] row_sat, col_w, row_w, col_adv_sat;
  logic       wrap, stop, printable, proceed, is_cr, is_lf;

  always_comb begin
    col_p5      = {1'b0, cursor_col} + COL_SPAN;
    wrap        = col_p5 > {2'b0, clip_right};
    row_p8      = {1'b0, cursor_row} + LINE_STEP;
    row_sat     = row_p8[8] ? 8'hFF : row_p8[7:0];
    col_w       = wrap ? {1'b0, clip_left} : cursor_col;
    row_w       = wrap ? row_sat : cursor_row;
    row_w_p7    = {1'b0, row_w} + ROW_SPAN;
    stop        = row_w_p7 > {4'b0, clip_bottom};
    col_adv     = {1'b0, col_w} + ADVANCE;
    col_adv_sat = col_adv[8] ? 8'hFF : col_adv[7:0];
    printable   = (code_q >= GLYPH_FIRST) && (code_q <= GLYPH_LAST);
    is_cr       = code_q == CODE_CR;
    is_lf       = code_q == CODE_LF;
    proceed     = !stopped && (code_q != CODE_NUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      stopped    <= 1'b0;
    end else if (cmd.exec) begin
      case (act_q)
        ACT_BEGIN: begin
          cursor_col <= {1'b0, sx_q};
          cursor_row <= {3'b0, sy_q};
          stopped    <= 1'b0;
        end
        ACT_DRAW: begin
          if (proceed) begin
            if (is_cr) begin
              cursor_col <= {1'b0, clip_left};
            end else if (is_lf) begin
              cursor_col <= {1'b0, clip_left};
              cursor_row <= row_sat;
            end else begin
              cursor_row <= row_w;
              if (stop) begin
                cursor_col <= col_w;
                stopped    <= 1'b1;
              end else if (printable) begin
                cursor_col <= col_adv_sat;
              end else begin
                cursor_col <= col_w;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      gx    <= col_w;
      gy    <= row_w;
      rd_ok <= (act_q == ACT_READ) && (32'(raddr_q) < 32'(STORE_BYTES));
    end
  end

  // one glyph row half per step: row = step/2, half selects the byte
  logic [2:0]            r;
  logic                  half;
  logic [6:0]            gidx;
  logic [7:0]            gidx_full;
  logic [GLYPH_COLS-1:0] gbits, pmask;
  logic [8:0]            py;
  logic                  row_ok;
  logic [11:0]           shifted;
  logic [7:0]            bmask;
  logic [5:0]            bytecol;
  logic [LIN_W-1:0]      lin;
  logic [ADDR_W-1:0]     draw_addr;
  logic [RA_W-1:0]       ra_ext;

  always_comb begin
    logic [8:0] px;
    r         = cmd.step[3:1];
    half      = cmd.step[0];
    gidx_full = code_q - GLYPH_FIRST;
    gidx      = gidx_full[6:0];
    gbits     = glyph_row(gidx, r);
    py        = {1'b0, gy} + {6'b0, r};
    row_ok    = (py >= {4'b0, clip_top}) && (py <= {4'b0, clip_bottom}) && ({1'b0, py} < SH10);
    for (int c = 0; c < GLYPH_COLS; c++) begin
      px = {1'b0, gx} + 9'(c);
      pmask[c] = gbits[c] && row_ok && (px >= {2'b0, clip_left}) &&
                 (px <= {2'b0, clip_right}) && ({1'b0, px} < SW10);
    end
    shifted   = 12'(pmask) << gx[2:0];
    bmask     = half ? {4'b0, shifted[11:8]} : shifted[7:0];
    bytecol   = {1'b0, gx[7:3]} + {5'b0, half};
    lin       = LIN_W'(py) * LIN_W'(ROW_BYTES) + LIN_W'(bytecol);
    draw_addr = lin[ADDR_W-1:0];
    ra_ext    = RA_W'(raddr_q);
    rd_addr   = cmd.draw ? draw_addr : ra_ext[ADDR_W-1:0];
  end

  assign sweep_last = sweep_cnt == ADDR_W'(STORE_BYTES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      wr_en_q   <= 1'b0;
    end else begin
      wr_en_q <= cmd.draw && (bmask != 8'h00);
      if (cmd.sweep) begin
        sweep_cnt <= sweep_last ? '0 : sweep_cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_q <= draw_addr;
    wr_mask_q <= bmask;
  end

  // framebuffer: one read port, one write port, registered read
  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    if (cmd.sweep) begin
      mem[sweep_cnt] <= 8'h00;
    end else if (wr_en_q) begin
      mem[wr_addr_q] <= mem_q | wr_mask_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data <= rd_ok ? mem_q : 8'h00;
      cursor_x  <= cursor_col;
      cursor_y  <= cursor_row;
      halted    <= stopped;
    end
  end

  always_comb begin
    status.act        = act_q;
    status.start_draw = (act_q == ACT_DRAW) && proceed && !is_cr && !is_lf && !stop &&
                        printable;
    status.sweep_last = sweep_last;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

// File: hw/rtl/font_text_renderer_with_clip_wrap.sv
// 5x7 bitmap text renderer into a one-bit framebuffer with clip box and wrap.
// A printable glyph is drawn in 14 pipelined byte read-modify-write steps on the single
// framebuffer write port; clear zeroes one byte a cycle over ROW_BYTES*SCREEN_HEIGHT bytes.
// Reset: synchronous, active high; a zeroing pass over ROW_BYTES*SCREEN_HEIGHT bytes
// follows, with s_tready low. One item at a time; the result register frees the input.
`timescale 1ns / 1ps

module font_text_renderer_with_clip_wrap #(
  parameter int SCREEN_WIDTH  = ftr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ftr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] action, [8:2] start_x, [13:9] start_y, [21:14] character_code,
  // [30:22] read_address, [31] zero
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_data, [15:8] cursor_x, [23:16] cursor_y, [24] halted, [31:25] zero
  output logic [31:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ftr_pkg::*;

  logic [6:0] clip_left, clip_right;
  logic [4:0] clip_top, clip_bottom;
  logic       cfg_write;
  reg_index_t cfg_index;

  ftr_cmd_t    cmd;
  ftr_status_t status;
  logic [7:0]  read_data, cursor_x, cursor_y;
  logic        halted;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= 7'd0;
      clip_top    <= 5'd0;
      clip_right  <= 7'd127;
      clip_bottom <= 5'd31;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CLIP_LEFT:   clip_left   <= pwdata[6:0];
        REG_CLIP_TOP:    clip_top    <= pwdata[4:0];
        REG_CLIP_RIGHT:  clip_right  <= pwdata[6:0];
        REG_CLIP_BOTTOM: clip_bottom <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_CLIP_LEFT:   prdata = {25'b0, clip_left};
      REG_CLIP_TOP:    prdata = {27'b0, clip_top};
      REG_CLIP_RIGHT:  prdata = {25'b0, clip_right};
      REG_CLIP_BOTTOM: prdata = {27'b0, clip_bottom};
      default:         prdata = '0;
    endcase
  end

  ftr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  ftr_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .action         (s_tdata[1:0]),
    .start_x        (s_tdata[8:2]),
    .start_y        (s_tdata[13:9]),
    .character_code (s_tdata[21:14]),
    .read_address   (s_tdata[30:22]),
    .clip_left      (clip_left),
    .clip_top       (clip_top),
    .clip_right     (clip_right),
    .clip_bottom    (clip_bottom),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .read_data      (read_data),
    .cursor_x       (cursor_x),
    .cursor_y       (cursor_y),
    .halted         (halted)
  );

  assign m_tdata = {7'b0, halted, cursor_y, cursor_x, read_data};

endmodule
